@@ design/plob_pkg.sv @@
// ----------------------------------------------------------------------------
// plob_pkg: shared types and constants of the price level order book
// Sizes, request and status codes, level record type.
// ----------------------------------------------------------------------------
package plob_pkg;
    localparam int LEVELS = 64;
    localparam int IDX_W  = $clog2(LEVELS);
    localparam int CNT_W  = $clog2(LEVELS + 1);
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 48;
    localparam int LVL_W   = PRICE_W + QTY_W;

    localparam logic [1:0] REQ_ADD     = 2'd0;
    localparam logic [1:0] REQ_DELETE  = 2'd1;
    localparam logic [1:0] REQ_CANCEL  = 2'd2;
    localparam logic [1:0] REQ_REPLACE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [QTY_W-1:0] QMAX = {QTY_W{1'b1}};

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } t_level;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
        logic [31:0] cxl_qty;
        logic [31:0] new_price;
        logic [31:0] new_qty;
    } t_req;

    typedef struct packed {
        logic [31:0] best_bid_price;
        logic [47:0] best_bid_qty;
        logic [31:0] best_ask_price;
        logic [47:0] best_ask_qty;
        logic [1:0]  status;
    } t_rsp;
endpackage

@@ design/plob_if.sv @@
// ----------------------------------------------------------------------------
// plob_req_if / plob_rsp_if: valid/ready channels
// Request and response channels of the order book.
// ----------------------------------------------------------------------------
interface plob_req_if;
    import plob_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface plob_rsp_if;
    import plob_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ design/plob_ram.sv @@
// ----------------------------------------------------------------------------
// plob_ram: generic single port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module plob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ design/price_level_order_book.sv @@
// ----------------------------------------------------------------------------
// price_level_order_book: two sided aggregate price level book
// Sorted bid and ask level memories with a sequencer for add/delete.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request (add, delete, cancel, replace) per handshake.
//   o_rsp returns one response per request: best bid and ask pairs and a
//   status. Levels live in one RAM per side, one level per word, with a
//   registered read. The sequencer scans a side from entry 0, one word per
//   cycle, to find the level; an insert shifts the tail one word at a time
//   through S_SHR, S_SHRD and S_SHW, a removal through S_SHLR and S_SHLW.
//   A replace runs both phases. One request at a time is in work; the next
//   is accepted after the response handshake, once the sequencer has passed
//   from S_DONE back to S_IDLE. A stalled receiver holds the response and
//   blocks new requests. Reset empties both sides (level counts to zero);
//   no memory clearing is needed since only entries below the count are used.
//   Best levels are held in registers and refreshed after each change.
// ----------------------------------------------------------------------------
module price_level_order_book (
    input  logic i_clk,
    input  logic i_rst_n,
    plob_req_if.sink   i_req,
    plob_rsp_if.source o_rsp
);
    import plob_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_SHR    = 4'd3;
    localparam logic [3:0] S_SHW    = 4'd4;
    localparam logic [3:0] S_SHRD   = 4'd5;
    localparam logic [3:0] S_SHLR   = 4'd6;
    localparam logic [3:0] S_SHLW   = 4'd7;
    localparam logic [3:0] S_BEST   = 4'd8;
    localparam logic [3:0] S_BESTW  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]       r_state, n_state;
    t_req             r_req;
    logic             r_add;        // current phase: add vs reduce
    logic [31:0]      r_price;
    logic [QTY_W-1:0] r_qty;        // add amount or reduction
    logic [CNT_W-1:0] r_cnt [2];
    logic [CNT_W-1:0] r_i;          // scan position
    logic [CNT_W-1:0] r_k;          // shift position
    logic             r_rd_pending;
    t_level           r_hold;       // word being inserted/carried
    logic [1:0]       r_status;
    logic             r_out_valid;
    t_rsp             rsp_word;
    t_level           r_best [2];

    logic             side;
    logic             ram_we [2];
    logic [IDX_W-1:0] ram_addr;
    t_level           ram_wdata;
    t_level           ram_rdata [2];
    t_level           rd;
    logic [CNT_W-1:0] n;

    assign side = r_req.side;
    assign rd   = ram_rdata[side];
    assign n    = r_cnt[side];

    for (genvar g = 0; g < 2; g++) begin : g_side
        plob_ram #(.WIDTH(LVL_W), .DEPTH(LEVELS)) u_ram (
            .i_clk  (i_clk),
            .i_we   (ram_we[g]),
            .i_addr (ram_addr),
            .i_wdata(ram_wdata),
            .o_rdata(ram_rdata[g])
        );
    end

    logic             stop_hit;
    logic             eq_hit;
    logic [QTY_W:0]   sum;
    logic [QTY_W-1:0] sat;

    always_comb begin
        if (r_add) begin
            stop_hit = side ? (rd.price >= r_price) : (rd.price <= r_price);
        end else begin
            stop_hit = (rd.price == r_price);
        end
        eq_hit = (rd.price == r_price);
        sum    = {1'b0, rd.qty} + {1'b0, r_qty};
        sat    = sum[QTY_W] ? QMAX : sum[QTY_W-1:0];
    end

    assign i_req.ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = rsp_word;

    always_comb begin
        ram_we[0] = 1'b0;
        ram_we[1] = 1'b0;
        ram_addr  = r_i[IDX_W-1:0];
        ram_wdata = r_hold;
        unique case (r_state)
            S_SCAN: begin
                // read ahead to the next entry while the current one misses
                ram_addr = (r_rd_pending && !stop_hit) ? r_i[IDX_W-1:0] + IDX_W'(1)
                                                       : r_i[IDX_W-1:0];
            end
            S_DECIDE: begin
                ram_addr = r_i[IDX_W-1:0];
                if (r_add && r_i < n && eq_hit) begin
                    ram_wdata = '{price: rd.price, qty: sat};
                    ram_we[side] = 1'b1;
                end else if (!r_add && r_i < n && r_qty < rd.qty) begin
                    ram_wdata = '{price: rd.price, qty: rd.qty - r_qty};
                    ram_we[side] = 1'b1;
                end
            end
            S_SHR:  ram_addr = r_k[IDX_W-1:0];
            S_SHRD: ram_addr = r_k[IDX_W-1:0];
            S_SHW: begin
                ram_addr = r_k[IDX_W-1:0];
                ram_wdata = r_hold;
                ram_we[side] = 1'b1;
            end
            S_SHLR: ram_addr = r_k[IDX_W-1:0];
            S_SHLW: begin
                ram_addr = r_k[IDX_W-1:0] - IDX_W'(1);
                ram_wdata = rd;
                ram_we[side] = 1'b1;
            end
            S_BEST:  ram_addr = '0;
            S_BESTW, S_DONE, S_IDLE: ram_addr = r_i[IDX_W-1:0];
            default: ram_addr = r_i[IDX_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_rd_pending <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req        <= i_req.data;
                        r_i          <= '0;
                        r_rd_pending <= 1'b0;
                        r_status     <= ST_OK;
                        r_price      <= i_req.data.price;
                        if (i_req.data.req_type == REQ_ADD) begin
                            r_add <= 1'b1;
                            r_qty <= QTY_W'(i_req.data.qty);
                        end else if (i_req.data.req_type == REQ_CANCEL) begin
                            r_add <= 1'b0;
                            r_qty <= (i_req.data.cxl_qty < i_req.data.qty) ?
                                     QTY_W'(i_req.data.cxl_qty) :
                                     QTY_W'(i_req.data.qty);
                        end else begin
                            r_add <= 1'b0;
                            r_qty <= QTY_W'(i_req.data.qty);
                        end
                    end
                end
                S_SCAN: begin
                    if (r_rd_pending && stop_hit) begin
                        r_rd_pending <= 1'b0;
                    end else if (r_rd_pending) begin
                        r_i <= r_i + CNT_W'(1);
                        r_rd_pending <= (r_i + CNT_W'(1)) < n;
                    end else begin
                        r_rd_pending <= r_i < n;
                    end
                end
                S_DECIDE: begin
                    // r_i is the stop position, rd its word if r_i < n
                    if (r_add) begin
                        if (!(r_i < n && eq_hit)) begin
                            if (n >= CNT_W'(LEVELS)) begin
                                // a not-found delete phase keeps its status
                                if (r_status == ST_OK) begin
                                    r_status <= ST_FULL;
                                end
                            end else begin
                                r_hold <= '{price: r_price, qty: r_qty};
                                r_k    <= r_i;
                                r_cnt[side] <= n + CNT_W'(1);
                            end
                        end
                    end else begin
                        if (!(r_i < n)) begin
                            r_status <= ST_NOTFOUND;
                        end else if (!(r_qty < rd.qty)) begin
                            r_k <= r_i + CNT_W'(1);
                        end
                    end
                end
                S_SHR: ;
                S_SHRD: ;
                S_SHW: begin
                    r_hold <= rd;
                    r_k    <= r_k + CNT_W'(1);
                end
                S_SHLR: ;
                S_SHLW: begin
                    r_k <= r_k + CNT_W'(1);
                end
                S_BEST: ;
                S_BESTW: begin
                    if (r_req.req_type == REQ_REPLACE && !r_add) begin
                        r_add   <= 1'b1;
                        r_price <= r_req.new_price;
                        r_qty   <= QTY_W'(r_req.new_qty);
                        r_i     <= '0;
                        r_rd_pending <= 1'b0;
                    end else begin
                        r_out_valid <= 1'b1;
                    end
                end
                S_DONE: ;
                default: ;
            endcase
            if (r_state == S_SHLW && !((r_k + CNT_W'(1)) < n)) begin
                r_cnt[side] <= n - CNT_W'(1);
            end
            if (r_state == S_DECIDE && !r_add && r_i < n && !(r_qty < rd.qty)
                && !((r_i + CNT_W'(1)) < n)) begin
                r_cnt[side] <= n - CNT_W'(1);
            end
        end
    end

    // shift-right phase: S_SHR reads k (kept only if k < old count),
    // S_SHRD waits, S_SHW writes hold at k and carries the old word
    logic [CNT_W-1:0] old_n;
    assign old_n = n - CNT_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_req.valid && i_req.ready) n_state = S_SCAN;
            S_SCAN: begin
                if ((r_rd_pending && stop_hit) ||
                    (r_rd_pending && !((r_i + CNT_W'(1)) < n)) ||
                    (!r_rd_pending && !(r_i < n))) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_add) begin
                    if ((r_i < n && eq_hit) || n >= CNT_W'(LEVELS)) begin
                        n_state = S_BEST;
                    end else begin
                        n_state = S_SHR;
                    end
                end else if (r_i < n && !(r_qty < rd.qty) &&
                             (r_i + CNT_W'(1)) < n) begin
                    n_state = S_SHLR;
                end else begin
                    n_state = S_BEST;
                end
            end
            S_SHR:  n_state = S_SHRD;
            S_SHRD: n_state = S_SHW;
            S_SHW:  n_state = (r_k < old_n) ? S_SHR : S_BEST;
            S_SHLR: n_state = S_SHLW;
            S_SHLW: n_state = ((r_k + CNT_W'(1)) < n) ? S_SHLR : S_BEST;
            S_BEST: n_state = S_BESTW;
            S_BESTW: begin
                n_state = (r_req.req_type == REQ_REPLACE && !r_add) ? S_SCAN : S_DONE;
            end
            S_DONE:  n_state = r_out_valid ? S_DONE : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // best registers: refreshed from word 0 of the active side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best[0] <= '0;
            r_best[1] <= '0;
        end else if (r_state == S_BESTW) begin
            r_best[side] <= (n != '0) ? rd : '0;
        end
    end

    always_comb begin
        rsp_word.best_bid_price = r_best[0].price;
        rsp_word.best_bid_qty   = r_best[0].qty;
        rsp_word.best_ask_price = r_best[1].price;
        rsp_word.best_ask_qty   = r_best[1].qty;
        rsp_word.status         = r_status;
    end
endmodule

@@ test/tb_plob_if.sv @@
// ----------------------------------------------------------------------------
// tb_plob_if: testbench package for the directed stimulus table
// The channel interfaces come from the design; this file only holds the
// small record type that the directed stimulus table uses.
// ----------------------------------------------------------------------------
package tb_plob_pkg;
    import plob_pkg::*;
    typedef struct packed {
        t_req       req;
        logic       known;
        t_rsp       rsp;
    } t_dir_row;
endpackage

@@ test/tb_price_level_order_book.sv @@
// ----------------------------------------------------------------------------
// tb_price_level_order_book: regression of the price level order book
// Directed table, ask side fill, then random order flow. Every response
// is checked against a behavioral book model kept in the testbench, under
// random idling on both channels, a long receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_price_level_order_book;
    timeunit 1ns;
    timeprecision 1ps;
    import plob_pkg::*;
    import tb_plob_pkg::*;

    localparam int N_RANDOM    = 354;
    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    plob_req_if req_ch();
    plob_rsp_if rsp_ch();

    price_level_order_book dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    // book model
    logic [PRICE_W-1:0] bk_price [2][LEVELS];
    logic [QTY_W-1:0]   bk_qty   [2][LEVELS];
    int                 bk_cnt   [2];

    t_rsp rsp_queue[$];
    int   errors = 0;
    int   n_checked = 0;
    int   n_full = 0, n_nf = 0;
    int   cycles = 0;
    int   snd_idle = 0, rcv_idle = 0;
    bit   rcv_hold = 0;

    function automatic logic [1:0] book_add(bit s, logic [31:0] p, logic [QTY_W-1:0] q);
        int n, i, k;
        logic [QTY_W:0] sum;
        n = bk_cnt[s];
        for (i = 0; i < n; i++)
            if (s ? (bk_price[s][i] >= p) : (bk_price[s][i] <= p)) break;
        if (i < n && bk_price[s][i] == p) begin
            sum = {1'b0, bk_qty[s][i]} + {1'b0, q};
            bk_qty[s][i] = sum[QTY_W] ? QMAX : sum[QTY_W-1:0];
            return ST_OK;
        end
        if (n >= LEVELS) return ST_FULL;
        for (k = n; k > i; k--) begin
            bk_price[s][k] = bk_price[s][k-1];
            bk_qty[s][k]   = bk_qty[s][k-1];
        end
        bk_price[s][i] = p;
        bk_qty[s][i]   = q;
        bk_cnt[s]      = n + 1;
        return ST_OK;
    endfunction

    function automatic logic [1:0] book_del(bit s, logic [31:0] p, logic [QTY_W-1:0] q);
        int n, i, k;
        n = bk_cnt[s];
        for (i = 0; i < n; i++)
            if (bk_price[s][i] == p) break;
        if (i >= n) return ST_NOTFOUND;
        if (q < bk_qty[s][i]) begin
            bk_qty[s][i] -= q;
            return ST_OK;
        end
        for (k = i; k + 1 < n; k++) begin
            bk_price[s][k] = bk_price[s][k+1];
            bk_qty[s][k]   = bk_qty[s][k+1];
        end
        bk_cnt[s] = n - 1;
        return ST_OK;
    endfunction

    function automatic t_rsp book_apply(t_req r);
        t_rsp o;
        logic [1:0] st, d;
        logic [31:0] red;
        case (r.req_type)
            REQ_ADD:    st = book_add(r.side, r.price, {16'd0, r.qty});
            REQ_DELETE: st = book_del(r.side, r.price, {16'd0, r.qty});
            REQ_CANCEL: begin
                red = (r.cxl_qty < r.qty) ? r.cxl_qty : r.qty;
                st = book_del(r.side, r.price, {16'd0, red});
            end
            default: begin
                d  = book_del(r.side, r.price, {16'd0, r.qty});
                st = book_add(r.side, r.new_price, {16'd0, r.new_qty});
                if (d != ST_OK) st = d;
            end
        endcase
        o.best_bid_price = bk_cnt[0] > 0 ? bk_price[0][0] : '0;
        o.best_bid_qty   = bk_cnt[0] > 0 ? bk_qty[0][0]   : '0;
        o.best_ask_price = bk_cnt[1] > 0 ? bk_price[1][0] : '0;
        o.best_ask_qty   = bk_cnt[1] > 0 ? bk_qty[1][0]   : '0;
        o.status = st;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH rsp %0d %s: got %0h want %0h", n_checked, what, got, want);
        errors++;
    endtask

    // response checker
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_queue.size() == 0) begin
                report_mismatch("unexpected", 64'(rsp_ch.data.status), 64'd0);
            end else begin
                t_rsp e;
                e = rsp_queue.pop_front();
                if (rsp_ch.data.best_bid_price !== e.best_bid_price)
                    report_mismatch("bid price", 64'(rsp_ch.data.best_bid_price),
                                    64'(e.best_bid_price));
                if (rsp_ch.data.best_bid_qty !== e.best_bid_qty)
                    report_mismatch("bid qty", 64'(rsp_ch.data.best_bid_qty),
                                    64'(e.best_bid_qty));
                if (rsp_ch.data.best_ask_price !== e.best_ask_price)
                    report_mismatch("ask price", 64'(rsp_ch.data.best_ask_price),
                                    64'(e.best_ask_price));
                if (rsp_ch.data.best_ask_qty !== e.best_ask_qty)
                    report_mismatch("ask qty", 64'(rsp_ch.data.best_ask_qty),
                                    64'(e.best_ask_qty));
                if (rsp_ch.data.status !== e.status)
                    report_mismatch("status", 64'(rsp_ch.data.status), 64'(e.status));
                if (e.status == ST_FULL) n_full++;
                if (e.status == ST_NOTFOUND) n_nf++;
            end
            n_checked++;
        end
    end

    // receiver
    initial rsp_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (rcv_hold) rsp_ch.ready <= 1'b0;
        else rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("price_level_order_book regression: fail");
            $finish;
        end
    end

    // returns at the accepting edge; valid stays up until an idle draw of the next
    // request or a drain pause takes it down at the following falling edge
    task automatic send_req(t_req r, bit known, t_rsp want);
        t_rsp p;
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.data  <= r;
        req_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        p = book_apply(r);
        if (known && p !== want) begin
            $display("table row disagrees with book model");
            errors++;
        end
        rsp_queue.push_back(p);
    endtask

    function automatic logic [31:0] pick_price(bit wide);
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return wide ? $urandom() : 32'd1000 + $urandom_range(95);
        endcase
    endfunction

    function automatic logic [31:0] pick_qty();
        case ($urandom_range(11))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(1, 500);
        endcase
    endfunction

    function automatic t_req rand_req(int phase);
        t_req r;
        r.req_type = $urandom_range(9) < 4 ? REQ_ADD : 2'($urandom_range(3));
        r.side = 1'($urandom_range(1));
        r.price = pick_price(phase == 1);
        // aim deletes at live levels most of the time
        if (r.req_type != REQ_ADD && bk_cnt[r.side] > 0 && $urandom_range(9) < 8)
            r.price = bk_price[r.side][$urandom_range(bk_cnt[r.side] - 1)];
        r.qty = pick_qty();
        r.cxl_qty = pick_qty();
        r.new_price = pick_price(phase == 1);
        r.new_qty = pick_qty();
        return r;
    endfunction

    function automatic t_req mk(logic [1:0] t, bit s, logic [31:0] p, logic [31:0] q,
                                logic [31:0] rq, logic [31:0] np, logic [31:0] nq);
        t_req r;
        r = '{req_type: t, side: s, price: p, qty: q, cxl_qty: rq,
              new_price: np, new_qty: nq};
        return r;
    endfunction

    function automatic t_rsp mr(logic [31:0] bp, logic [47:0] bq, logic [31:0] ap,
                                logic [47:0] aq, logic [1:0] st);
        t_rsp o;
        o = '{best_bid_price: bp, best_bid_qty: bq, best_ask_price: ap,
              best_ask_qty: aq, status: st};
        return o;
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (rsp_queue.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    t_dir_row dir_tbl[$];
    t_req     rq;
    int       i, ph;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        bk_cnt = '{0, 0};
        // directed table; known responses only where trivially read off
        dir_tbl.push_back('{mk(REQ_DELETE, 0, 32'd5, 32'd1, 0, 0, 0), 1,
                            mr(0, 0, 0, 0, ST_NOTFOUND)});
        dir_tbl.push_back('{mk(REQ_CANCEL, 1, 32'd5, 32'd1, 32'd1, 0, 0), 1,
                            mr(0, 0, 0, 0, ST_NOTFOUND)});
        dir_tbl.push_back('{mk(REQ_ADD, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0), 1,
                            mr(32'hFFFF_FFFF, 48'hFFFF_FFFF, 0, 0, ST_OK)});
        dir_tbl.push_back('{mk(REQ_ADD, 1, 32'd0, 32'd0, 0, 0, 0), 1,
                            mr(32'hFFFF_FFFF, 48'hFFFF_FFFF, 0, 0, ST_OK)});
        dir_tbl.push_back('{mk(REQ_ADD, 0, 32'd100, 32'd10, 0, 0, 0), 0, '0});
        dir_tbl.push_back('{mk(REQ_ADD, 1, 32'd200, 32'd7, 0, 0, 0), 0, '0});
        dir_tbl.push_back('{mk(REQ_ADD, 0, 32'd100, 32'd5, 0, 0, 0), 0, '0});
        dir_tbl.push_back('{mk(REQ_DELETE, 0, 32'd100, 32'd3, 0, 0, 0), 0, '0});
        dir_tbl.push_back('{mk(REQ_CANCEL, 0, 32'd100, 32'd20, 32'd4, 0, 0), 0, '0});
        dir_tbl.push_back('{mk(REQ_CANCEL, 0, 32'd100, 32'd2, 32'd9, 0, 0), 0, '0});
        dir_tbl.push_back('{mk(REQ_DELETE, 1, 32'd0, 32'd0, 0, 0, 0), 0, '0});
        dir_tbl.push_back('{mk(REQ_REPLACE, 1, 32'd200, 32'd7, 0, 32'd150, 32'd9), 0, '0});
        dir_tbl.push_back('{mk(REQ_REPLACE, 1, 32'd999, 32'd1, 0, 32'd150, 32'd1), 0, '0});
        dir_tbl.push_back('{mk(REQ_REPLACE, 0, 32'd100, 32'd1, 0, 32'd90, 32'hFFFF_FFFF),
                            0, '0});
        dir_tbl.push_back('{mk(REQ_DELETE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, '0});
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        snd_idle = 30; rcv_idle = 65;
        foreach (dir_tbl[k]) send_req(dir_tbl[k].req, dir_tbl[k].known, dir_tbl[k].rsp);

        // fill the ask side to capacity, then hit side full and merge into it
        for (i = 0; i < LEVELS + 2; i++)
            send_req(mk(REQ_ADD, 1, 32'd5000 + i, 32'hFFFF_FFFF, 0, 0, 0), 0, '0);
        for (i = 0; i < 3; i++)
            send_req(mk(REQ_ADD, 1, 32'd5000, 32'hFFFF_FFFF, 0, 0, 0), 0, '0);
        for (i = 0; i < 70000; i++)
            if (i % 8 == 0) send_req(mk(REQ_ADD, 1, 32'd5000, 32'hFFFF_FFFF, 0, 0, 0),
                                     0, '0);
            else if (i > 40) break;

        // long receiver hold-off while requests keep coming
        fork
            begin
                rcv_hold = 1;
                repeat (300) @(negedge i_clk);
                rcv_hold = 0;
            end
            for (int j = 0; j < 6; j++) send_req(rand_req(0), 0, '0);
        join
        wait_drained();

        for (ph = 0; ph < 3; ph++) begin
            if (ph == 0) begin snd_idle = 30; rcv_idle = 65; end
            else if (ph == 1) begin snd_idle = 65; rcv_idle = 30; end
            else begin snd_idle = 0; rcv_idle = 0; end
            for (i = 0; i < N_RANDOM / 3; i++) begin
                rq = rand_req(ph);
                send_req(rq, 0, '0);
            end
            wait_drained();
        end

        repeat (400) @(negedge i_clk);
        $display("checked %0d responses, %0d side-full and %0d not-found statuses",
                 n_checked, n_full, n_nf);
        $display("bid/ask levels left: %0d/%0d, errors %0d", bk_cnt[0], bk_cnt[1], errors);
        if (errors == 0 && rsp_queue.size() == 0)
            $display("price_level_order_book regression: pass");
        else
            $display("price_level_order_book regression: fail");
        $finish;
    end
endmodule
